/* src/ps2_command_packet_sender_macros.svh */
// Assertion macros shared by the PS/2 command packet sender RTL.
// Depends on nothing; the asserting modules include it by bare file name.
// PS2CPS_ASSERT uses the enclosing module's clock and reset signals.
`ifndef PS2_COMMAND_PACKET_SENDER_MACROS_SVH
`define PS2_COMMAND_PACKET_SENDER_MACROS_SVH

`ifndef SYNTHESIS

`define PS2CPS_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define PS2CPS_ASSERT(label, prop, msg) \
   `PS2CPS_ASSERT_CLK(label, clock, reset, prop, msg)

`else

`define PS2CPS_ASSERT_CLK(label, clk, rst, prop, msg)

`define PS2CPS_ASSERT(label, prop, msg)

`endif

`endif

/* src/ps2cps_pkg.sv */
// Types and constants for the PS/2 command packet sender.
// Used by the sender control, packet store and top level; depends on nothing.
package ps2cps_pkg;

   localparam int POS_W   = 5;
   localparam int TALLY_W = 9;
   // byte_index is four bits wide, so no more than this many entries can be loaded
   localparam int INDEX_SPAN = 16;

   typedef logic [POS_W-1:0]   pos_type;
   typedef logic [TALLY_W-1:0] tally_type;

   localparam logic [7:0] REPLY_RESEND       = 8'hFE;
   localparam logic [7:0] REPLY_NACK         = 8'hFC;
   localparam logic [7:0] RESEND_LIMIT_RESET = 8'd3;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_REPLY = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_PENDING = 3'd0,
      ST_SUCCESS = 3'd1,
      ST_TIMEOUT = 3'd2,
      ST_DEVERR  = 3'd3,
      ST_BUSY    = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  byte_index;
      logic [7:0]  byte_value;
      logic [4:0]  byte_count;
      logic        to_mouse;
      logic [7:0]  reply;
      logic        write_blocked;
   } req_type;

   typedef struct packed {
      logic        issue_write;
      logic        route_prefix;
      logic [7:0]  write_data;
      logic        reply_taken;
      logic        done_res;
      status_type  status;
   } rsp_type;

endpackage

/* src/ps2cps_req_if.sv */
// Request channel of the PS/2 command packet sender: valid/ready plus item fields.
// Depends on nothing.
interface ps2cps_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [3:0]  byte_index;
   logic [7:0]  byte_value;
   logic [4:0]  byte_count;
   logic        to_mouse;
   logic [7:0]  reply;
   logic        write_blocked;

   modport source (
      output valid, cmd, byte_index, byte_value, byte_count, to_mouse, reply,
             write_blocked,
      input  ready
   );

   modport sink (
      input  valid, cmd, byte_index, byte_value, byte_count, to_mouse, reply,
             write_blocked,
      output ready
   );
endinterface

/* src/ps2cps_rsp_if.sv */
// Response channel of the PS/2 command packet sender: valid/ready plus result fields.
// Depends on nothing.
interface ps2cps_rsp_if;
   logic        valid;
   logic        ready;
   logic        issue_write;
   logic        route_prefix;
   logic [7:0]  write_data;
   logic        reply_taken;
   logic        done_res;
   logic [2:0]  status;

   modport source (
      output valid, issue_write, route_prefix, write_data, reply_taken, done_res, status,
      input  ready
   );

   modport sink (
      input  valid, issue_write, route_prefix, write_data, reply_taken, done_res, status,
      output ready
   );
endinterface

/* src/ps2_command_packet_sender.sv */
// PS/2 command packet sender, top level.
//
// Channels: req_bus carries load, start, reply and no-op items; rsp_bus returns
// exactly one result per item, in order. csr_write_en/csr_write_data set the resend
// limit (reset value 3); write it only while no item is in flight.
// Load items fill the packet store; a start item sends byte 0 (flagged for the
// mouse route command when to_mouse is set) unless the sender is busy or the write
// is blocked; each device reply then acknowledges, repeats or ends the packet.
// Pipeline: each request passes through an input register and a result register
// around one pass of step logic.
// Throughput: one item per cycle while rsp_bus.ready stays high; the step logic
// updates all sender state in one pass.
// Reset: synchronous, clears both pipeline valid bits and the sender state, and sets
// the resend limit to 3; the packet store is not cleared and must be loaded
// before use.
// Stall: while rsp_bus.ready is low the result holds, one further item is taken into
// the input register if it is empty, then req_bus.ready drops.
`include "ps2_command_packet_sender_macros.svh"

module ps2_command_packet_sender import ps2cps_pkg::*; #(
   parameter int MAX_PACKET = 16
) (
   input  logic               clock,
   input  logic               reset,
   ps2cps_req_if.sink         req_bus,
   ps2cps_rsp_if.source       rsp_bus,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_item_ff, in_item_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_item_ff;
   rsp_type  step_result;
   logic     req_transfer;
   logic     advance;

   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_transfer  = req_bus.valid && req_bus.ready;

   always_comb begin
      in_item_in.cmd           = cmd_type'(req_bus.cmd);
      in_item_in.byte_index    = req_bus.byte_index;
      in_item_in.byte_value    = req_bus.byte_value;
      in_item_in.byte_count    = req_bus.byte_count;
      in_item_in.to_mouse      = req_bus.to_mouse;
      in_item_in.reply         = req_bus.reply;
      in_item_in.write_blocked = req_bus.write_blocked;
   end

   always_comb begin
      priority if (req_transfer) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   ps2cps_ctrl #(
      .MAX_PACKET (MAX_PACKET)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .step_en        (advance),
      .item           (in_item_ff),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .result         (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: input loads on request transfer, result on advance; hold otherwise
   always_ff @(posedge clock) begin
      if (req_transfer) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.issue_write  = rsp_item_ff.issue_write;
   assign rsp_bus.route_prefix = rsp_item_ff.route_prefix;
   assign rsp_bus.write_data   = rsp_item_ff.write_data;
   assign rsp_bus.reply_taken  = rsp_item_ff.reply_taken;
   assign rsp_bus.done_res     = rsp_item_ff.done_res;
   assign rsp_bus.status       = rsp_item_ff.status;

   `PS2CPS_ASSERT(a_transfer_lands,
      req_transfer |=> in_valid_ff,
      "accepted request did not reach the input register")
   `PS2CPS_ASSERT(a_advance_presents,
      advance |=> rsp_valid_ff,
      "stepped item did not produce a result")
   `PS2CPS_ASSERT(a_idle_write_fields,
      (rsp_valid_ff && !rsp_item_ff.issue_write)
         |-> (rsp_item_ff.write_data == 8'h00 && !rsp_item_ff.route_prefix),
      "write fields set on a result without a byte sent")

endmodule

/* src/ps2cps_store.sv */
// Packet byte store: flip-flop array, one write port, one asynchronous read port.
// Depends on ps2cps_pkg for the position type.
module ps2cps_store import ps2cps_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  pos_type                  rd_addr,
   output logic [7:0]               rd_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   logic [7:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // positions past the loadable range were never written; return zero
   assign rd_data = (int'(rd_addr) < DEPTH) ? mem_ff[rd_addr[ADDR_W-1:0]] : 8'h00;

endmodule

/* src/ps2cps_ctrl.sv */
// Packet send control: sender state, resend tally, limit register and step logic.
// Depends on ps2cps_pkg, ps2cps_store and the assertion macro header.
`include "ps2_command_packet_sender_macros.svh"

module ps2cps_ctrl import ps2cps_pkg::*; #(
   parameter int MAX_PACKET = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step_en,
   input  req_type     item,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data,
   output rsp_type     result
);

   localparam int STORE_DEPTH = (MAX_PACKET < INDEX_SPAN) ? MAX_PACKET : INDEX_SPAN;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   logic        sending_ff, sending_in;
   pos_type     next_position_ff, next_position_in;
   pos_type     packet_length_ff, packet_length_in;
   tally_type   resend_tally_ff, resend_tally_in;
   logic        target_mouse_ff, target_mouse_in;
   logic [7:0]  resend_limit_ff;

   tally_type   tally_inc;
   logic        resend_tolerated;
   pos_type     pos_eff;
   pos_type     count_sat;
   logic        store_wr_en;
   logic [7:0]  rd_data;

   assign tally_inc        = tally_type'(resend_tally_ff + 1'b1);
   assign resend_tolerated = tally_inc <= {1'b0, resend_limit_ff};
   assign count_sat        = (int'(item.byte_count) > MAX_PACKET) ? pos_type'(MAX_PACKET)
                                                                  : item.byte_count;
   assign store_wr_en      = step_en && (item.cmd == CMD_LOAD)
                             && (int'(item.byte_index) < MAX_PACKET);

   // byte position for this step: zero on a start, back one on a tolerated resend
   always_comb begin
      pos_eff = next_position_ff;
      if (item.cmd == CMD_START) begin
         pos_eff = '0;
      end else if (item.cmd == CMD_REPLY && item.reply == REPLY_RESEND && resend_tolerated
                   && next_position_ff != '0) begin
         pos_eff = pos_type'(next_position_ff - 1'b1);
      end
   end

   ps2cps_store #(
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_wr_en),
      .wr_addr (item.byte_index[ADDR_W-1:0]),
      .wr_data (item.byte_value),
      .rd_addr (pos_eff),
      .rd_data (rd_data)
   );

   always_comb begin
      logic closed;
      closed           = 1'b0;
      sending_in       = sending_ff;
      next_position_in = next_position_ff;
      packet_length_in = packet_length_ff;
      resend_tally_in  = resend_tally_ff;
      target_mouse_in  = target_mouse_ff;
      result           = '0;
      result.status    = ST_PENDING;

      unique case (item.cmd)
         CMD_START: begin
            if (sending_ff) begin
               result.done_res = 1'b1;
               result.status   = ST_BUSY;
            end else begin
               packet_length_in = count_sat;
               target_mouse_in  = item.to_mouse;
               next_position_in = '0;
               resend_tally_in  = '0;
               if (item.write_blocked) begin
                  result.done_res = 1'b1;
                  result.status   = ST_TIMEOUT;
               end else begin
                  sending_in          = 1'b1;
                  result.issue_write  = 1'b1;
                  result.route_prefix = item.to_mouse;
                  result.write_data   = rd_data;
                  next_position_in    = pos_type'(pos_eff + 1'b1);
               end
            end
         end
         CMD_REPLY: begin
            if (sending_ff) begin
               result.reply_taken = 1'b1;
               priority if (item.reply == REPLY_RESEND) begin
                  if (!resend_tolerated) begin
                     resend_tally_in = '0;
                     closed          = 1'b1;
                     sending_in      = 1'b0;
                     result.done_res = 1'b1;
                     result.status   = ST_TIMEOUT;
                  end else begin
                     resend_tally_in = tally_inc;
                  end
               end else if (item.reply == REPLY_NACK) begin
                  resend_tally_in = '0;
                  closed          = 1'b1;
                  sending_in      = 1'b0;
                  result.done_res = 1'b1;
                  result.status   = ST_DEVERR;
               end else begin
                  resend_tally_in = '0;
               end

               if (!closed) begin
                  priority if (pos_eff >= packet_length_ff) begin
                     sending_in      = 1'b0;
                     result.done_res = 1'b1;
                     result.status   = ST_SUCCESS;
                  end else if (item.write_blocked) begin
                     sending_in      = 1'b0;
                     result.done_res = 1'b1;
                     result.status   = ST_TIMEOUT;
                  end else begin
                     result.issue_write  = 1'b1;
                     result.route_prefix = target_mouse_ff;
                     result.write_data   = rd_data;
                     next_position_in    = pos_type'(pos_eff + 1'b1);
                  end
               end
               next_position_in = closed ? next_position_ff : next_position_in;
               if (!closed && !result.issue_write) begin
                  next_position_in = pos_eff;
               end
            end
         end
         CMD_LOAD, CMD_NOP: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff       <= 1'b0;
         next_position_ff <= '0;
         packet_length_ff <= '0;
         resend_tally_ff  <= '0;
         target_mouse_ff  <= 1'b0;
      end else if (step_en) begin
         sending_ff       <= sending_in;
         next_position_ff <= next_position_in;
         packet_length_ff <= packet_length_in;
         resend_tally_ff  <= resend_tally_in;
         target_mouse_ff  <= target_mouse_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resend_limit_ff <= RESEND_LIMIT_RESET;
      end else if (csr_write_en) begin
         resend_limit_ff <= csr_write_data;
      end
   end

   `PS2CPS_ASSERT(a_start_sends_byte,
      $rose(sending_ff) |-> $past(step_en && result.issue_write),
      "packet became active without a byte being sent")
   `PS2CPS_ASSERT(a_idle_reply_ignored,
      (step_en && item.cmd == CMD_REPLY && !sending_ff) |-> (result == '0),
      "reply while idle produced a non-zero result")
   `PS2CPS_ASSERT(a_position_bound,
      sending_ff |-> (next_position_ff <= packet_length_ff || packet_length_ff == '0),
      "send position ran past the packet length")

endmodule

/* sim/tb.sv */
// Self-checking testbench for ps2_command_packet_sender: drives load, start, reply
// and no-op transfers, predicts every result and compares it field by field.
// Depends on ps2cps_pkg, ps2cps_req_if, ps2cps_rsp_if and the RTL top level.
`timescale 1ns / 100ps

module tb;
   import ps2cps_pkg::*;

   localparam int STORE_DEPTH = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_write_en;
   logic [7:0] csr_write_data;
   bit         calm;

   ps2cps_req_if req();
   ps2cps_rsp_if rsp();

   ps2_command_packet_sender #(.MAX_PACKET(STORE_DEPTH)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req),
      .rsp_bus        (rsp),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   class packet_sender_scoreboard;
      logic [7:0] resend_limit;
      bit         sending;
      pos_type    next_pos;
      pos_type    packet_len;
      tally_type  resend_tally;
      bit         target_mouse;
      logic [7:0] store [STORE_DEPTH];
      rsp_type    expected_q[$];
      int         errors;
      int         transfers_in;
      int         results_checked;
      int         endings [5];

      function new();
         resend_limit = RESEND_LIMIT_RESET;
         sending      = 1'b0;
         next_pos     = '0;
         packet_len   = '0;
         resend_tally = '0;
         target_mouse = 1'b0;
         errors       = 0;
         foreach (endings[k]) endings[k] = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void send_byte(inout rsp_type r);
         r.issue_write  = 1'b1;
         r.route_prefix = target_mouse;
         r.write_data   = store[next_pos[3:0]];
         next_pos++;
      endfunction

      function void end_packet(inout rsp_type r, input status_type st);
         sending    = 1'b0;
         r.done_res = 1'b1;
         r.status   = st;
      endfunction

      // Move on after an acknowledgement or a tolerated resend
      function void advance(inout rsp_type r, input logic blocked);
         if (next_pos >= packet_len)
            end_packet(r, ST_SUCCESS);
         else if (blocked)
            end_packet(r, ST_TIMEOUT);
         else
            send_byte(r);
      endfunction

      function void note_request(input req_type it);
         rsp_type r;
         r = '0;
         transfers_in++;
         case (it.cmd)
            CMD_LOAD: begin
               store[it.byte_index] = it.byte_value;
            end
            CMD_START: begin
               if (sending) begin
                  r.done_res = 1'b1;
                  r.status   = ST_BUSY;
               end else begin
                  packet_len   = (it.byte_count > STORE_DEPTH) ? pos_type'(STORE_DEPTH)
                                                               : it.byte_count;
                  target_mouse = it.to_mouse;
                  next_pos     = '0;
                  resend_tally = '0;
                  if (it.write_blocked) begin
                     r.done_res = 1'b1;
                     r.status   = ST_TIMEOUT;
                  end else begin
                     sending = 1'b1;
                     send_byte(r);
                  end
               end
            end
            CMD_REPLY: begin
               if (sending) begin
                  r.reply_taken = 1'b1;
                  if (it.reply == REPLY_RESEND) begin
                     resend_tally++;
                     if (resend_tally > resend_limit) begin
                        resend_tally = '0;
                        end_packet(r, ST_TIMEOUT);
                     end else begin
                        if (next_pos > 0) next_pos--;
                        advance(r, it.write_blocked);
                     end
                  end else if (it.reply == REPLY_NACK) begin
                     resend_tally = '0;
                     end_packet(r, ST_DEVERR);
                  end else begin
                     resend_tally = '0;
                     advance(r, it.write_blocked);
                  end
               end
            end
            default: ;
         endcase
         if (r.done_res) endings[r.status]++;
         expected_q.push_back(r);
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(input rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $error("result transfer with no request outstanding");
            errors++;
            return;
         end
         want = expected_q.pop_front();
         results_checked++;
         compare_field("issue_write", 8'(want.issue_write), 8'(got.issue_write));
         compare_field("route_prefix", 8'(want.route_prefix), 8'(got.route_prefix));
         compare_field("write_data", want.write_data, got.write_data);
         compare_field("reply_taken", 8'(want.reply_taken), 8'(got.reply_taken));
         compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
         compare_field("status", 8'(want.status), 8'(got.status));
      endfunction
   endclass

   packet_sender_scoreboard sb;

   // Result side: take and check transfers, stall at random unless calm is set
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready)
            sb.check_result('{issue_write: rsp.issue_write, route_prefix: rsp.route_prefix,
                              write_data: rsp.write_data, reply_taken: rsp.reply_taken,
                              done_res: rsp.done_res, status: status_type'(rsp.status)});
         rsp.ready <= calm || ($urandom_range(0, 99) >= 27);
      end
   end

   function automatic req_type any_item();
      req_type     it;
      logic [31:0] w;
      w = $urandom;
      it.cmd           = cmd_type'(w[1:0]);
      it.byte_index    = w[5:2];
      it.byte_value    = w[13:6];
      it.byte_count    = w[18:14];
      it.to_mouse      = w[19];
      it.reply         = w[27:20];
      it.write_blocked = w[28];
      return it;
   endfunction

   function automatic req_type load_item(input logic [3:0] idx, input logic [7:0] val);
      req_type it;
      it = any_item();
      it.cmd        = CMD_LOAD;
      it.byte_index = idx;
      it.byte_value = val;
      return it;
   endfunction

   function automatic req_type start_item(input logic [4:0] cnt, input logic mouse,
                                          input logic blocked);
      req_type it;
      it = any_item();
      it.cmd           = CMD_START;
      it.byte_count    = cnt;
      it.to_mouse      = mouse;
      it.write_blocked = blocked;
      return it;
   endfunction

   function automatic req_type reply_item(input logic [7:0] rep, input logic blocked);
      req_type it;
      it = any_item();
      it.cmd           = CMD_REPLY;
      it.reply         = rep;
      it.write_blocked = blocked;
      return it;
   endfunction

   function automatic logic [7:0] ack_byte();
      logic [7:0] v;
      do v = 8'($urandom); while (v == REPLY_RESEND || v == REPLY_NACK);
      return v;
   endfunction

   function automatic logic [4:0] packet_count();
      int p;
      p = $urandom_range(0, 99);
      if (p < 80) return 5'($urandom_range(1, 6));
      if (p < 90) return 5'($urandom_range(7, STORE_DEPTH));
      return 5'($urandom_range(0, 31));
   endfunction

   // Mostly well-formed packet traffic with random content, some noise
   function automatic req_type pick_item();
      int p;
      int q;
      p = $urandom_range(0, 99);
      if (p < 8) return any_item();
      if (!sb.sending) begin
         if (p < 35)
            return load_item(4'($urandom), 8'($urandom));
         return start_item(packet_count(), 1'($urandom), $urandom_range(0, 9) == 0);
      end
      if (p < 12) return load_item(4'($urandom), 8'($urandom));
      if (p < 16) return start_item(packet_count(), 1'($urandom), 1'($urandom));
      q = $urandom_range(0, 99);
      if (q < 22) return reply_item(REPLY_RESEND, $urandom_range(0, 19) == 0);
      if (q < 27) return reply_item(REPLY_NACK, 1'($urandom));
      return reply_item(ack_byte(), $urandom_range(0, 19) == 0);
   endfunction

   task automatic drive_item(input req_type it);
      while (!calm && $urandom_range(0, 99) < 27) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.cmd           <= it.cmd;
      req.byte_index    <= it.byte_index;
      req.byte_value    <= it.byte_value;
      req.byte_count    <= it.byte_count;
      req.to_mouse      <= it.to_mouse;
      req.reply         <= it.reply;
      req.write_blocked <= it.write_blocked;
      do @(posedge clock); while (!req.ready);
      sb.note_request(it);
   endtask

   task automatic await_drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_resend_limit(input logic [7:0] v);
      await_drain();
      repeat (3) @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.resend_limit = v;
   endtask

   // Start a packet and answer it with a run of resends; ack if it survives
   task automatic resend_burst(input int n);
      int k;
      if (sb.sending) drive_item(reply_item(REPLY_NACK, 1'b0));
      drive_item(start_item(5'($urandom_range(2, 5)), 1'($urandom), 1'b0));
      for (k = 0; k < n; k++) drive_item(reply_item(REPLY_RESEND, 1'b0));
      if (sb.sending) drive_item(reply_item(ack_byte(), 1'b0));
   endtask

   task automatic run_random_items(input int n);
      int      taken;
      req_type it;
      taken = 0;
      while (taken < n) begin
         it = pick_item();
         if (!(it.cmd == CMD_NOP || (it.cmd == CMD_REPLY && !sb.sending))) taken++;
         drive_item(it);
      end
   endtask

   initial begin
      logic [7:0] fill [STORE_DEPTH];
      logic [7:0] mid_limit;
      int         k;
      sb = new();
      calm = 1'b0;
      csr_write_en   <= 1'b0;
      csr_write_data <= '0;
      req.valid      <= 1'b0;
      req.cmd        <= CMD_NOP;
      req.byte_index <= '0;
      req.byte_value <= '0;
      req.byte_count <= '0;
      req.to_mouse   <= 1'b0;
      req.reply      <= '0;
      req.write_blocked <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole store first so no unwritten entry is ever sent
      fill = '{8'h00, 8'hFF, REPLY_RESEND, REPLY_NACK, 8'hD4, 8'h55, 8'hAA, 8'h01,
               8'h80, 8'h7F, 8'hED, 8'hF4, 8'hF3, 8'h0F, 8'hF0, 8'h3C};
      for (k = 0; k < STORE_DEPTH; k++) drive_item(load_item(4'(k), fill[k]));

      // Directed cases at the reset resend limit
      drive_item(any_item());
      begin
         req_type it;
         it = any_item();
         it.cmd = CMD_NOP;
         drive_item(it);
      end
      drive_item(reply_item(ack_byte(), 1'b0));          // reply while idle
      drive_item(start_item(5'd0, 1'b1, 1'b0));           // empty packet, mouse route
      drive_item(load_item(4'd1, 8'hC3));                 // load while sending
      drive_item(reply_item(8'h00, 1'b0));
      drive_item(start_item(5'd3, 1'b0, 1'b1));           // blocked start
      drive_item(start_item(5'd31, 1'b0, 1'b0));          // over-long count saturates
      drive_item(start_item(5'd2, 1'b1, 1'b0));           // busy
      drive_item(reply_item(8'hFF, 1'b0));
      drive_item(reply_item(8'hFA, 1'b1));                // blocked mid-packet write
      drive_item(start_item(5'd2, 1'b1, 1'b0));
      for (k = 0; k < 4; k++) drive_item(reply_item(REPLY_RESEND, 1'b0));
      drive_item(start_item(5'd16, 1'b0, 1'b0));
      drive_item(reply_item(8'hFA, 1'b0));
      drive_item(reply_item(REPLY_NACK, 1'b0));

      write_resend_limit(8'd0);
      resend_burst(1);
      resend_burst(0);
      run_random_items(220);

      // No idling on either side for this whole phase
      write_resend_limit(8'd255);
      calm = 1'b1;
      resend_burst(256);
      resend_burst(255);
      run_random_items(220);
      await_drain();
      calm = 1'b0;

      write_resend_limit(8'd1);
      resend_burst(2);
      run_random_items(110);
      await_drain();
      run_random_items(110);

      mid_limit = 8'($urandom_range(2, 254));
      write_resend_limit(mid_limit);
      resend_burst(int'(mid_limit) + 1);
      run_random_items(220);

      await_drain();
      repeat (10) @(posedge clock);
      $display("Run covered %0d request transfers and %0d checked results, resend limits 3, 0, 255, 1 and %0d.",
               sb.transfers_in, sb.results_checked, mid_limit);
      $display("Endings seen: %0d success, %0d timeout, %0d device error, %0d busy.",
               sb.endings[ST_SUCCESS], sb.endings[ST_TIMEOUT], sb.endings[ST_DEVERR],
               sb.endings[ST_BUSY]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("ps2_command_packet_sender: match");
      else
         $display("ps2_command_packet_sender: mismatch");
      $finish;
   end

   initial begin
      #(10_000_000);
      $display("ps2_command_packet_sender: mismatch");
      $finish;
   end

endmodule
